[rtl/silu_pkg.sv]
// ----------------------------------------------------------------------------
// silu_pkg
// shared constants, types and the sigmoid table for the quantized silu block
// ----------------------------------------------------------------------------
package silu_pkg;

  localparam int SIGMOID_SEGMENTS = 64;
  localparam int SEG_W = $clog2(SIGMOID_SEGMENTS + 1);
  localparam int IDX_W = $clog2(SIGMOID_SEGMENTS + 1);
  localparam int A_W = 40;
  localparam int P_W = 47;

  typedef enum logic [1:0] {
    REG_INPUT_SCALE   = 2'd0,
    REG_SIGMOID_RECIP = 2'd1,
    REG_REQUANT_RATIO = 2'd2
  } reg_index_t;

  typedef logic [15:0] rom_t [SIGMOID_SEGMENTS + 1];

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic            last;
    logic [A_W-1:0]  a;
    logic [15:0]     lo;
    logic            up;
    logic [39:0]     prod;
  } lut_t;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic            last;
    logic [P_W-1:0]  p;
  } prod_t;

  // shift-subtract quotient, only evaluated while the table is built
  function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
    logic [63:0] quo;
    logic [63:0] r;
    quo = '0;
    r   = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r      = r - d;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] den;
    logic        done;
    for (int k = 0; k <= SIGMOID_SEGMENTS; k++) begin
      t    = div_u64(64'(k) << 27, 64'(SIGMOID_SEGMENTS));
      sum  = 64'd1 << 24;
      term = 64'd1 << 24;
      done = 1'b0;
      for (int j = 1; j < 64; j++) begin
        if (!done) begin
          term = div_u64((term * t) >> 24, 64'(j));
          if (term == 64'd0) done = 1'b1;
          else sum = sum + term;
        end
      end
      den = sum + (64'd1 << 24);
      rom[k] = 16'(div_u64(sum * 64'd65536 + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

[rtl/silu_if.sv]
// ----------------------------------------------------------------------------
// silu_in_if / silu_out_if
// valid/ready channels for activations and results
// ----------------------------------------------------------------------------
interface silu_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] x_value;
  logic              last_in;
  modport source (output valid, x_value, last_in, input ready);
  modport sink (input valid, x_value, last_in, output ready);
endinterface

interface silu_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] y_value;
  logic              last_out;
  modport source (output valid, y_value, last_out, input ready);
  modport sink (input valid, y_value, last_out, output ready);
endinterface

[rtl/silu_lut.sv]
// ----------------------------------------------------------------------------
// silu_lut
// dequantization and piecewise-linear sigmoid lookup (two stages)
// ----------------------------------------------------------------------------
module silu_lut (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid,
  input  logic signed [7:0]   x_value,
  input  logic                last_in,
  input  logic [31:0]         input_scale_q,
  output silu_pkg::lut_t      q
);
  import silu_pkg::*;

  localparam int PF_W = A_W + SEG_W;

  logic             v1, neg1, last1;
  logic [A_W-1:0]   a1;
  logic             neg_c;
  logic [8:0]       xmag;
  logic [PF_W-1:0]  pfull;
  logic [PF_W-25:0] idx;
  logic [23:0]      frac;
  logic             sat;
  logic [IDX_W-1:0] i_lo, i_hi;
  logic [15:0]      lo, hi, diff;

  assign neg_c = x_value[7];
  assign xmag  = neg_c ? 9'(9'd256 - {1'b0, x_value}) : {1'b0, x_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= valid;
    end
    if (en) begin
      neg1  <= neg_c;
      last1 <= last_in;
      a1    <= A_W'(xmag) * A_W'(input_scale_q);
    end
  end

  assign pfull = (PF_W'(a1) * PF_W'(SIGMOID_SEGMENTS)) >> 3;
  assign idx   = pfull[PF_W-1:24];
  assign frac  = pfull[23:0];
  assign sat   = idx >= (PF_W-24)'(SIGMOID_SEGMENTS);
  assign i_lo  = sat ? IDX_W'(SIGMOID_SEGMENTS) : idx[IDX_W-1:0];
  assign i_hi  = sat ? IDX_W'(SIGMOID_SEGMENTS) : IDX_W'(idx[IDX_W-1:0] + 1'b1);
  assign lo    = SIG_ROM[i_lo];
  assign hi    = SIG_ROM[i_hi];
  assign diff  = (hi >= lo) ? 16'(hi - lo) : 16'(lo - hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= v1;
    end
    if (en) begin
      q.neg  <= neg1;
      q.last <= last1;
      q.a    <= a1;
      q.lo   <= lo;
      q.up   <= hi >= lo;
      q.prod <= sat ? 40'd0 : 40'(diff) * 40'(frac);
    end
  end
endmodule

[rtl/silu_sq.sv]
// ----------------------------------------------------------------------------
// silu_sq
// interpolation, sigmoid requantization and product with |r| (two stages)
// ----------------------------------------------------------------------------
module silu_sq (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  silu_pkg::lut_t   d,
  input  logic [31:0]      sigmoid_recip_q,
  output silu_pkg::prod_t  q
);
  import silu_pkg::*;

  logic            v3, neg3, last3;
  logic [A_W-1:0]  a3;
  logic [48:0]     m3;
  logic [15:0]     delta;
  logic [16:0]     s, sn;
  logic [16:0]     qi;
  logic [17:0]     qr;
  logic            rnd;
  logic [6:0]      sq;

  assign delta = 16'((d.prod + 40'd8388608) >> 24);
  assign s     = d.up ? 17'(d.lo) + 17'(delta) : 17'(d.lo) - 17'(delta);
  assign sn    = d.neg ? 17'(17'd65536 - s) : s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= d.valid;
    end
    if (en) begin
      neg3  <= d.neg;
      last3 <= d.last;
      a3    <= d.a;
      m3    <= 49'(sn) * 49'(sigmoid_recip_q);
    end
  end

  assign qi  = m3[48:32];
  assign rnd = (m3[31:0] > 32'h8000_0000) || ((m3[31:0] == 32'h8000_0000) && qi[0]);
  assign qr  = 18'(qi) + 18'(rnd);
  assign sq  = (qr > 18'd127) ? 7'd127 : qr[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= v3;
    end
    if (en) begin
      q.neg  <= neg3;
      q.last <= last3;
      q.p    <= P_W'(a3) * P_W'(sq);
    end
  end
endmodule

[rtl/silu_out.sv]
// ----------------------------------------------------------------------------
// silu_out
// final ratio multiply, half-to-even rounding and int8 saturation
// ----------------------------------------------------------------------------
module silu_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  silu_pkg::prod_t    d,
  input  logic [31:0]        requant_ratio_q,
  output logic               valid,
  output logic signed [7:0]  y_value,
  output logic               last_out
);
  import silu_pkg::*;

  logic        v5, neg5, last5;
  logic [54:0] big_a;
  logic [55:0] big_b;
  logic [55:0] c;
  logic [31:0] m;
  logic [47:0] rem;
  logic        rnd;
  logic [32:0] mr;
  logic [7:0]  mag, y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= d.valid;
    end
    if (en) begin
      neg5  <= d.neg;
      last5 <= d.last;
      big_a <= 55'(d.p[P_W-1:24]) * 55'(requant_ratio_q);
      big_b <= 56'(d.p[23:0]) * 56'(requant_ratio_q);
    end
  end

  assign c   = 56'(big_a) + (big_b >> 24);
  assign m   = c[55:24];
  assign rem = {c[23:0], big_b[23:0]};
  assign rnd = (rem > 48'h8000_0000_0000) || ((rem == 48'h8000_0000_0000) && m[0]);
  assign mr  = 33'(m) + 33'(rnd);
  assign mag = (mr > 33'd128) ? 8'd128 : mr[7:0];
  assign y   = neg5 ? 8'(9'd256 - 9'(mag)) : ((mag > 8'd127) ? 8'd127 : mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v5;
    end
    if (en) begin
      y_value  <= y;
      last_out <= last5;
    end
  end
endmodule

[rtl/silu_int8_requant.sv]
// ----------------------------------------------------------------------------
// silu_int8_requant
// quantized int8 silu with two-step fixed-point requantization
// ----------------------------------------------------------------------------
// One beat in and one beat out per cycle while the output is not stalled. The
// six register stages are dequantize, table lookup, interpolate and scale,
// requantize sigmoid, ratio multiply, and round and saturate into the output
// register. The whole pipeline advances together and holds while the output
// beat waits, so ready follows the output side. Registers must be written by the
// user only while the pipeline is empty; the block itself does not enforce this.
module silu_int8_requant (
  input  logic        clk,
  input  logic        rst,
  silu_in_if.sink     act,
  silu_out_if.source  res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import silu_pkg::*;

  logic [31:0] input_scale_q, sigmoid_recip_q, requant_ratio_q;
  logic        en;
  lut_t        lut;
  prod_t       prd;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_scale_q   <= 32'd16777216;
      sigmoid_recip_q <= 32'd8323072;
      requant_ratio_q <= 32'd16777216;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_SCALE:   input_scale_q   <= cfg_data;
        REG_SIGMOID_RECIP: sigmoid_recip_q <= cfg_data;
        REG_REQUANT_RATIO: requant_ratio_q <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !res.valid || res.ready;
  assign act.ready = en;

  silu_lut u_lut (
    .clk, .rst, .en,
    .valid(act.valid), .x_value(act.x_value), .last_in(act.last_in),
    .input_scale_q, .q(lut)
  );

  silu_sq u_sq (
    .clk, .rst, .en, .d(lut), .sigmoid_recip_q, .q(prd)
  );

  silu_out u_out (
    .clk, .rst, .en, .d(prd), .requant_ratio_q,
    .valid(res.valid), .y_value(res.y_value), .last_out(res.last_out)
  );
endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// checks the quantized silu block against an integer predictor of its
// dequantize, table sigmoid, requantize and ratio steps, with random stalls
// on both channels and several register settings
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import silu_pkg::*;

  typedef struct packed {
    logic signed [7:0] y;
    logic              last;
  } silu_res_t;

  typedef struct packed {
    logic signed [7:0] x;
    logic              last;
  } act_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_INPUT_SCALE;
  logic [31:0] cfg_data = '0;

  silu_in_if  act ();
  silu_out_if res ();

  silu_int8_requant dut (
    .clk(clk), .rst(rst), .act(act), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [31:0] scale_in, recip_sig, ratio_req;
  logic [31:0] sig_table [SIGMOID_SEGMENTS + 1];
  act_beat_t   pending_beats [$];
  silu_res_t   expected_silu [$];
  int          errors = 0;
  int          send_idle = 10, recv_idle = 75;
  bit          hold_send = 0;
  longint      cycles = 0;

  function automatic logic [63:0] exp_fixed(logic [63:0] t);
    logic [63:0] sum, term;
    sum = 64'd1 << 24;
    term = sum;
    for (int k = 1; k < 64; k++) begin
      term = ((term * t) >> 24) / 64'(k);
      if (term == 0) break;
      sum += term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] sig_mag(logic [63:0] a);
    logic [63:0] p, idx, frac, lo, hi;
    p = (a * SIGMOID_SEGMENTS) >> 3;
    idx = p >> 24;
    frac = p & 64'hFFFFFF;
    if (idx >= SIGMOID_SEGMENTS) return sig_table[SIGMOID_SEGMENTS];
    lo = sig_table[idx];
    hi = sig_table[idx + 1];
    if (hi >= lo) return lo + (((hi - lo) * frac + 64'h800000) >> 24);
    return lo - (((lo - hi) * frac + 64'h800000) >> 24);
  endfunction

  function automatic silu_res_t silu_predict(act_beat_t b);
    silu_res_t   r;
    logic        neg;
    logic [63:0] xm, a, s, v, sq, p, ba, bb, c, m, rem;
    neg = b.x[7];
    xm = neg ? 64'(256 - {1'b0, b.x[7:0]}) : 64'(b.x[7:0]);
    a = xm * scale_in;
    s = sig_mag(a);
    if (neg) s = 65536 - s;
    v = s * recip_sig;
    sq = v >> 32;
    if (v[31:0] > 32'h8000_0000 || (v[31:0] == 32'h8000_0000 && sq[0])) sq++;
    if (sq > 127) sq = 127;
    p = a * sq;
    ba = (p >> 24) * ratio_req;
    bb = (p & 64'hFFFFFF) * ratio_req;
    c = ba + (bb >> 24);
    m = c >> 24;
    rem = ((c & 64'hFFFFFF) << 24) | (bb & 64'hFFFFFF);
    if (rem > (64'd1 << 47) || (rem == (64'd1 << 47) && m[0])) m++;
    if (m > 128) m = 128;
    if (neg) r.y = 8'((256 - m) & 64'hFF);
    else r.y = 8'((m > 127) ? 127 : m);
    r.last = b.last;
    return r;
  endfunction

  initial begin
    for (int k = 0; k <= SIGMOID_SEGMENTS; k++) begin
      logic [63:0] t, e, den;
      t = (64'(k) << 27) / SIGMOID_SEGMENTS;
      e = exp_fixed(t);
      den = e + (64'd1 << 24);
      sig_table[k] = 32'((e * 65536 + den / 2) / den);
    end
  end

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      act.valid <= 1'b0;
      act.x_value <= '0;
      act.last_in <= 1'b0;
    end else begin
      if (act.valid && act.ready) begin
        expected_silu.push_back(silu_predict({act.x_value, act.last_in}));
        void'(pending_beats.pop_front());
      end
      if (pending_beats.size() > (act.valid && act.ready ? 0 : 0) && !hold_send &&
          $urandom_range(99) >= send_idle) begin
        act.valid <= 1'b1;
        act.x_value <= pending_beats[0].x;
        act.last_in <= pending_beats[0].last;
      end else if (!(act.valid && !act.ready)) begin
        act.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_silu.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          silu_res_t e;
          e = expected_silu.pop_front();
          if (res.y_value !== e.y) begin
            $error("y_value expected %0d got %0d", e.y, res.y_value);
            errors++;
          end
          if (res.last_out !== e.last) begin
            $error("last_out expected %0d got %0d", e.last, res.last_out);
            errors++;
          end
        end
      end
      res.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_beats.size() != 0 || act.valid || expected_silu.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INPUT_SCALE:   scale_in = v;
      REG_SIGMOID_RECIP: recip_sig = v;
      default:           ratio_req = v;
    endcase
  endtask

  task automatic queue_beat(logic signed [7:0] x, logic l);
    act_beat_t b;
    b.x = x;
    b.last = l;
    pending_beats.push_back(b);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) queue_beat(8'($urandom), ($urandom_range(15) == 0));
  endtask

  initial begin
    logic [31:0] cfgs [8][3];
    scale_in = 32'd16777216;
    recip_sig = 32'd8323072;
    ratio_req = 32'd16777216;
    cfgs = '{
      '{32'h0100_0000, 32'h007F_0000, 32'h0100_0000},
      '{32'h0008_0000, 32'h0080_0000, 32'h0400_0000},
      '{32'h0000_0000, 32'h007F_0000, 32'h0100_0000},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'h0020_0000, 32'h0000_0000, 32'h0100_0000},
      '{32'h0010_0000, 32'h0100_0000, 32'h0000_0000},
      '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001},
      '{32'h0004_0000, 32'h007F_8000, 32'h0800_0000}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (cfgs[i]) begin
      if (i == 3) begin
        send_idle = 75;
        recv_idle = 10;
      end else if (i == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(REG_INPUT_SCALE, cfgs[i][0]);
      write_reg(REG_SIGMOID_RECIP, cfgs[i][1]);
      write_reg(REG_REQUANT_RATIO, cfgs[i][2]);
      if (i == 0) begin
        queue_beat(-128, 0); queue_beat(127, 1); queue_beat(0, 0);
        queue_beat(-1, 0); queue_beat(1, 1); queue_beat(64, 0);
        queue_beat(-64, 0); queue_beat(8, 0); queue_beat(-8, 1);
        queue_beat(7, 0); queue_beat(-7, 0); queue_beat(85, 1);
        queue_beat(-86, 0); queue_beat(42, 0); queue_beat(-43, 1);
      end
      queue_random(40);
      if (i == 1) begin
        wait (pending_beats.size() <= 20);
        hold_send = 1;
        wait (expected_silu.size() == 0 && !act.valid);
        hold_send = 0;
      end
      drain();
    end
    for (int j = 0; j < 4; j++) begin
      write_reg(REG_INPUT_SCALE, $urandom_range(32'h0200_0000));
      write_reg(REG_SIGMOID_RECIP, $urandom);
      write_reg(REG_REQUANT_RATIO, $urandom_range(32'h1000_0000));
      queue_random(30);
      drain();
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
